[hw/rtl/tcpts_pkg.sv]
// Shared types and constants for the TCP timestamp / window scale option scanner.
// Used by tcpts_in_stage, tcpts_scan and tcp_option_ts_wscale_scan_core.
// No dependencies.
`default_nettype none

package tcpts_pkg;

   // Option kinds that the scanner acts on.
   localparam logic [7:0] KIND_EOL    = 8'd0;
   localparam logic [7:0] KIND_NOP    = 8'd1;
   localparam logic [7:0] KIND_WSCALE = 8'd3;
   localparam logic [7:0] KIND_TS     = 8'd8;

   // Option sizes that must fit inside the area, shift clamp and minimum length.
   localparam logic [6:0] TS_SPAN     = 7'd10;
   localparam logic [6:0] WS_SPAN     = 7'd3;
   localparam logic [7:0] WS_MAX      = 8'd14;
   localparam logic [7:0] MIN_OPT_LEN = 8'd2;

   // Byte position saturates here.
   localparam logic [5:0] POS_MAX     = 6'd63;

   typedef struct packed {
      logic [7:0] opt_byte;
      logic [5:0] opt_len;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic        ts_found;
      logic [31:0] ts_value;
      logic        ws_found;
      logic [14:0] ws_factor;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/tcpts_in_stage.sv]
// Input register of the option scanner: holds one accepted word until the scan stage takes it.
// Depends on tcpts_pkg.
`default_nettype none

module tcpts_in_stage (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [7:0]          req_opt_byte,
   input  wire  [5:0]          req_opt_len,
   input  wire                 req_last_byte,
   input  wire                 item_take,
   output logic                item_vld,
   output tcpts_pkg::item_type item
);

   logic                in_vld_ff;
   tcpts_pkg::item_type item_ff;

   // The register can load whenever it is empty or is being emptied this cycle.
   assign req_stall = in_vld_ff && !item_take;
   assign item_vld  = in_vld_ff;
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff.opt_byte  <= req_opt_byte;
         item_ff.opt_len   <= req_opt_len;
         item_ff.last_byte <= req_last_byte;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/tcpts_scan.sv]
// Scan stage: walks the option bytes, tracks timestamp and window scale, and holds the result.
// Depends on tcpts_pkg.
`default_nettype none

module tcpts_scan #(
   parameter int MAX_OPT_BYTES = 40
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   item_vld,
   input  tcpts_pkg::item_type   item,
   output logic                  item_take,
   output logic                  rsp_vld,
   input  wire                   rsp_stall,
   output tcpts_pkg::result_type rsp
);

   localparam logic [5:0] LEN_CAP = 6'(MAX_OPT_BYTES);

   logic [5:0]  byte_pos_ff, byte_pos_in;
   logic [8:0]  next_opt_start_ff, next_opt_start_in;
   logic        scan_stopped_ff, scan_stopped_in;
   logic        len_wait_ff, len_wait_in;
   logic        ts_capture_ff, ts_capture_in;
   logic [5:0]  ts_start_ff, ts_start_in;
   logic [31:0] ts_shift_ff, ts_shift_in;
   logic        ts_seen_ff, ts_seen_in;
   logic        ws_pend_ff, ws_pend_in;
   logic [5:0]  ws_pos_ff, ws_pos_in;
   logic [3:0]  ws_shift_ff, ws_shift_in;
   logic        ws_seen_ff, ws_seen_in;

   logic                  rsp_vld_ff;
   tcpts_pkg::result_type rsp_ff;
   tcpts_pkg::result_type rsp_in;

   logic [5:0] len_eff;
   logic [6:0] pos7;
   logic [6:0] ts_lo, ts_hi;
   logic [7:0] b;

   // A closing word needs a free result register; other words always move on.
   assign item_take = item_vld && (!item.last_byte || !(rsp_vld_ff && rsp_stall));
   assign rsp_vld   = rsp_vld_ff;
   assign rsp       = rsp_ff;

   assign len_eff = (item.opt_len > LEN_CAP) ? LEN_CAP : item.opt_len;
   assign pos7    = {1'b0, byte_pos_ff};
   assign ts_lo   = {1'b0, ts_start_ff} + 7'd2;
   assign ts_hi   = {1'b0, ts_start_ff} + 7'd5;
   assign b       = item.opt_byte;

   always_comb begin
      byte_pos_in       = byte_pos_ff;
      next_opt_start_in = next_opt_start_ff;
      scan_stopped_in   = scan_stopped_ff;
      len_wait_in       = len_wait_ff;
      ts_capture_in     = ts_capture_ff;
      ts_start_in       = ts_start_ff;
      ts_shift_in       = ts_shift_ff;
      ts_seen_in        = ts_seen_ff;
      ws_pend_in        = ws_pend_ff;
      ws_pos_in         = ws_pos_ff;
      ws_shift_in       = ws_shift_ff;
      ws_seen_in        = ws_seen_ff;

      if (byte_pos_ff < len_eff) begin
         // Value bytes of options that started earlier.
         if (ts_capture_ff && pos7 >= ts_lo && pos7 <= ts_hi) begin
            ts_shift_in = {ts_shift_ff[23:0], b};
            if (pos7 == ts_hi) begin
               ts_capture_in = 1'b0;
            end
         end
         if (ws_pend_ff && byte_pos_ff == ws_pos_ff) begin
            ws_shift_in = (b > tcpts_pkg::WS_MAX) ? 4'(tcpts_pkg::WS_MAX) : b[3:0];
            ws_pend_in  = 1'b0;
         end

         // Option walk.
         if (!scan_stopped_ff) begin
            if (len_wait_ff) begin
               if ({4'b0, byte_pos_ff} == {1'b0, next_opt_start_ff} + 10'd1) begin
                  len_wait_in = 1'b0;
                  if (b < tcpts_pkg::MIN_OPT_LEN) begin
                     scan_stopped_in = 1'b1;
                  end else begin
                     next_opt_start_in = next_opt_start_ff + {1'b0, b};
                  end
               end
            end else if ({3'b0, byte_pos_ff} == next_opt_start_ff) begin
               if (b == tcpts_pkg::KIND_EOL) begin
                  scan_stopped_in = 1'b1;
               end else if (b == tcpts_pkg::KIND_NOP) begin
                  next_opt_start_in = {3'b0, byte_pos_ff} + 9'd1;
               end else begin
                  len_wait_in = 1'b1;
                  if (b == tcpts_pkg::KIND_TS
                      && pos7 + tcpts_pkg::TS_SPAN <= {1'b0, len_eff}) begin
                     ts_seen_in    = 1'b1;
                     ts_capture_in = 1'b1;
                     ts_start_in   = byte_pos_ff;
                     ts_shift_in   = 32'd0;
                  end
                  if (b == tcpts_pkg::KIND_WSCALE
                      && pos7 + tcpts_pkg::WS_SPAN <= {1'b0, len_eff}) begin
                     ws_seen_in = 1'b1;
                     ws_pend_in = 1'b1;
                     ws_pos_in  = byte_pos_ff + 6'd2;
                  end
               end
            end
         end
      end

      if (byte_pos_ff != tcpts_pkg::POS_MAX) begin
         byte_pos_in = byte_pos_ff + 6'd1;
      end

      // The result reflects the state after this word.
      rsp_in.ts_found  = ts_seen_in;
      rsp_in.ts_value  = ts_seen_in ? ts_shift_in : 32'd0;
      rsp_in.ws_found  = ws_seen_in;
      rsp_in.ws_factor = ws_seen_in ? (15'd1 << ws_shift_in) : 15'd1;

      // The closing word returns the walk to its starting state.
      if (item.last_byte) begin
         byte_pos_in       = 6'd0;
         next_opt_start_in = 9'd0;
         scan_stopped_in   = 1'b0;
         len_wait_in       = 1'b0;
         ts_capture_in     = 1'b0;
         ts_start_in       = 6'd0;
         ts_shift_in       = 32'd0;
         ts_seen_in        = 1'b0;
         ws_pend_in        = 1'b0;
         ws_pos_in         = 6'd0;
         ws_shift_in       = 4'd0;
         ws_seen_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff       <= 6'd0;
         next_opt_start_ff <= 9'd0;
         scan_stopped_ff   <= 1'b0;
         len_wait_ff       <= 1'b0;
         ts_capture_ff     <= 1'b0;
         ts_start_ff       <= 6'd0;
         ts_shift_ff       <= 32'd0;
         ts_seen_ff        <= 1'b0;
         ws_pend_ff        <= 1'b0;
         ws_pos_ff         <= 6'd0;
         ws_shift_ff       <= 4'd0;
         ws_seen_ff        <= 1'b0;
      end else if (item_take) begin
         byte_pos_ff       <= byte_pos_in;
         next_opt_start_ff <= next_opt_start_in;
         scan_stopped_ff   <= scan_stopped_in;
         len_wait_ff       <= len_wait_in;
         ts_capture_ff     <= ts_capture_in;
         ts_start_ff       <= ts_start_in;
         ts_shift_ff       <= ts_shift_in;
         ts_seen_ff        <= ts_seen_in;
         ws_pend_ff        <= ws_pend_in;
         ws_pos_ff         <= ws_pos_in;
         ws_shift_ff       <= ws_shift_in;
         ws_seen_ff        <= ws_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (item_take && item.last_byte) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && item.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/tcp_option_ts_wscale_scan_core.sv]
// Top level of the TCP option scanner for the timestamp and window scale options.
// Depends on tcpts_pkg, tcpts_in_stage and tcpts_scan.
//
// Usage: the TCP option area of a segment enters on the req_ channel one byte per word,
// with the area length on every word and req_last_byte set on the final word. An empty
// area is sent as a single word with req_opt_len of zero and req_last_byte set. Bytes at
// or past the length are ignored, but the last mark still closes the segment.
// For every word with req_last_byte set, one word leaves on the rsp_ channel: the timestamp
// and window scale found flags, the TSval of the latest eligible timestamp option (zero if
// none) and the window factor, 1 shifted left by the clamped shift (1 if none).
// Flow: a closing word accepted into the input register is scanned from there and lands in
// the result register, which then drives rsp_valid. Throughput is one word per cycle while
// no closing word waits on a stalled result, set by the single scan pass between those two
// registers; the scan state carries across bytes there.
// When the receiver stalls, the result register holds its word; non-closing bytes keep
// flowing into the scan, and a closing byte waits in the input register, which then raises
// req_stall until the result is taken.
// Reset is synchronous and clears the scan state and both valid flags; after reset the
// block expects the first byte of a new option area.
`default_nettype none

module tcp_option_ts_wscale_scan_core #(
   parameter int MAX_OPT_BYTES = 40
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_opt_byte,
   input  wire  [5:0]  req_opt_len,
   input  wire         req_last_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_ts_found,
   output logic [31:0] rsp_ts_value,
   output logic        rsp_ws_found,
   output logic [14:0] rsp_ws_factor
);

   logic                  item_vld;
   logic                  item_take;
   tcpts_pkg::item_type   item;
   tcpts_pkg::result_type rsp;

   // Input register: decouples the sender from a stalled result.
   tcpts_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opt_byte  (req_opt_byte),
      .req_opt_len   (req_opt_len),
      .req_last_byte (req_last_byte),
      .item_take     (item_take),
      .item_vld      (item_vld),
      .item          (item)
   );

   // Scan pass and result register.
   tcpts_scan #(
      .MAX_OPT_BYTES (MAX_OPT_BYTES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .item_vld  (item_vld),
      .item      (item),
      .item_take (item_take),
      .rsp_vld   (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_ts_found  = rsp.ts_found;
   assign rsp_ts_value  = rsp.ts_value;
   assign rsp_ws_found  = rsp.ws_found;
   assign rsp_ws_factor = rsp.ws_factor;

   // The input register only pushes back when it holds a word.
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_vld)
      else $error("req_stall raised with an empty input register");

   // The window factor is always a single power of two.
   a_factor_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_ws_factor))
      else $error("window factor is not a power of two");

   // Without a window scale option the factor is the default of one.
   a_factor_default: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ws_found) |-> (rsp_ws_factor == 15'd1))
      else $error("window factor not one without window scale option");

   // Without a timestamp option the value reads zero.
   a_ts_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ts_found) |-> (rsp_ts_value == 32'd0))
      else $error("timestamp value nonzero without timestamp option");

endmodule

`default_nettype wire
